@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL. They are empty when
// SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check on every rising edge, skip while reset is high
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/lph_pkg.sv @@
// ---------------------------------------------------------------------------
// lph_pkg
// Types and constants of the linear probing hash table.
// ---------------------------------------------------------------------------
package lph_pkg;

  // Field widths
  localparam int KEY_W  = 16;
  localparam int DATA_W = 32;
  localparam int SLOT_W = 3;

  // Default number of slots
  localparam int TABLE_SIZE_DEF = 8;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_SEARCH = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_FOUND     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE
  } state_t;

  typedef struct packed {
    action_t             action;
    logic [KEY_W-1:0]    key;
    logic [DATA_W-1:0]   entry_data;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
    logic [KEY_W-1:0]    found_key;
    logic [DATA_W-1:0]   found_data;
  } out_item_t;

  // One table entry as held in memory
  typedef struct packed {
    logic                valid;
    logic [KEY_W-1:0]    key;
    logic [DATA_W-1:0]   data;
  } entry_t;

endpackage

@@ rtl/lph_ram.sv @@
// ---------------------------------------------------------------------------
// lph_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module lph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/lph_mod.sv @@
// ---------------------------------------------------------------------------
// lph_mod
// Home slot unit: key modulo TABLE_SIZE by multiplying with a fixed
// reciprocal, then subtracting quotient times TABLE_SIZE.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lph_mod #(
  parameter int TABLE_SIZE = lph_pkg::TABLE_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lph_pkg::KEY_W-1:0]     key,
  output logic                          done,
  output logic [$clog2(TABLE_SIZE)-1:0] home
);

  import lph_pkg::*;

  localparam int IDX_W   = $clog2(TABLE_SIZE);
  localparam int REM_W   = IDX_W + 1;
  localparam int SHIFT   = KEY_W + IDX_W;
  localparam int RECIP_W = KEY_W + 1;
  localparam int PROD_W  = KEY_W + RECIP_W;
  localparam int Q_W     = PROD_W - SHIFT;
  // ceil(2^SHIFT / TABLE_SIZE) gives the exact quotient for every key
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));
  localparam logic [KEY_W-1:0]   TS_KEY = KEY_W'(TABLE_SIZE);
  localparam logic [REM_W-1:0]   TS_EXT = REM_W'(TABLE_SIZE);

  logic              stage1;
  logic              stage2;
  logic [KEY_W-1:0]  key_q;
  logic [Q_W-1:0]    quot;
  logic [PROD_W-1:0] prod;
  logic [KEY_W-1:0]  rem_full;
  logic [IDX_W-1:0]  rem;

  // Scale the key by the reciprocal; the top bits are the quotient
  assign prod = PROD_W'(key_q) * PROD_W'(RECIP);

  // Take the remainder from the quotient
  assign rem_full = key_q - KEY_W'(quot) * TS_KEY;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      stage2 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= start;
      stage2 <= stage1;
      done   <= stage2;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      key_q <= key;
    end
    if (stage1) begin
      quot <= prod[PROD_W-1:SHIFT];
    end
    if (stage2) begin
      rem <= rem_full[IDX_W-1:0];
    end
  end

  assign home = rem;

  `ASSERT_RST(a_mod_no_restart, clk, rst, (stage1 || stage2) |-> !start, "home unit restarted while working")
  `ASSERT_RST(a_mod_done_pulse, clk, rst, done |-> !(stage1 || stage2), "home unit done while still working")
  `ASSERT_RST(a_mod_rem_range, clk, rst, done |-> (REM_W'(rem) < TS_EXT), "home slot out of range")

endmodule

@@ rtl/linear_probe_hash_table.sv @@
// ---------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressed table of TABLE_SIZE slots with linear probing and wrap.
// ---------------------------------------------------------------------------
// After reset the block is busy while it clears the valid marks in memory,
// one slot per cycle. A beat is taken when start is high and busy is low;
// busy then stays high until the result. The home slot is computed in the
// reciprocal unit, then the probe reads one slot per cycle from the table
// memory, whose read port is registered. A beat probes 1 to TABLE_SIZE
// slots. The done strobe lasts one cycle; results cannot be held off, and
// the next beat may be started in the strobe cycle.
`include "assert_macros.svh"

module linear_probe_hash_table #(
  parameter int TABLE_SIZE = lph_pkg::TABLE_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  lph_pkg::in_item_t  request,
  output logic               done,
  output lph_pkg::out_item_t result
);

  import lph_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int CNT_W = $clog2(TABLE_SIZE + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
  localparam logic [CNT_W-1:0] CNT_ALL  = CNT_W'(TABLE_SIZE);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_SIZE - 1);

  state_t state, state_next;

  in_item_t         item_q;
  logic [IDX_W-1:0] clr_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [CNT_W-1:0] issued;
  logic             resp_vld;
  logic [IDX_W-1:0] resp_idx;
  logic             resp_last;

  logic             mod_start;
  logic             mod_done;
  logic [IDX_W-1:0] home;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic             issue;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t           rd_entry;

  logic             finish;
  logic             ins_hit;
  out_item_t        res_next;

  // Home slot unit
  lph_mod #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_mod (
    .clk  (clk),
    .rst  (rst),
    .start(mod_start),
    .key  (request.key),
    .done (mod_done),
    .home (home)
  );

  // Table memory: valid mark, key and data word per slot
  lph_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_SIZE)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (issue),
    .raddr(rd_idx),
    .rdata(ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  // Evaluate the slot that came back from memory
  always_comb begin
    logic match;
    match    = rd_entry.valid && (rd_entry.key == item_q.key);
    finish   = 1'b0;
    ins_hit  = 1'b0;
    res_next = '0;
    res_next.status = ST_NOT_FOUND;
    if (resp_vld) begin
      unique case (item_q.action)
        ACT_INSERT: begin
          if (!rd_entry.valid) begin
            finish              = 1'b1;
            ins_hit             = 1'b1;
            res_next.status     = ST_INSERTED;
            res_next.slot       = SLOT_W'(resp_idx);
            res_next.found_key  = item_q.key;
            res_next.found_data = item_q.entry_data;
          end else if (resp_last) begin
            finish          = 1'b1;
            res_next.status = ST_FULL;
          end
        end
        ACT_SEARCH: begin
          if (match) begin
            finish              = 1'b1;
            res_next.status     = ST_FOUND;
            res_next.slot       = SLOT_W'(resp_idx);
            res_next.found_key  = rd_entry.key;
            res_next.found_data = rd_entry.data;
          end else if (!rd_entry.valid || resp_last) begin
            finish          = 1'b1;
            res_next.status = ST_NOT_FOUND;
          end
        end
        default: begin
          finish = 1'b0;
        end
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_idx == LAST_IDX) state_next = S_IDLE;
      S_IDLE:  if (start) state_next = S_HASH;
      S_HASH:  if (mod_done) state_next = S_PROBE;
      S_PROBE: if (finish) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    busy      = 1'b1;
    mod_start = 1'b0;
    issue     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = clr_idx;
    ram_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        busy      = 1'b0;
        mod_start = start;
      end
      S_HASH: begin
        busy = 1'b1;
      end
      S_PROBE: begin
        issue = (issued != CNT_ALL) && !finish;
        if (ins_hit) begin
          ram_we          = 1'b1;
          ram_waddr       = resp_idx;
          ram_wdata.valid = 1'b1;
          ram_wdata.key   = item_q.key;
          ram_wdata.data  = item_q.entry_data;
        end
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_idx  <= '0;
      resp_vld <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      resp_vld <= issue;
      done     <= finish;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  // Hold the beat, advance the probe, capture the result
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      item_q <= request;
    end
    if (state == S_HASH && mod_done) begin
      rd_idx <= home;
      issued <= '0;
    end else if (issue) begin
      rd_idx <= (rd_idx == LAST_IDX) ? '0 : rd_idx + 1'b1;
      issued <= issued + 1'b1;
    end
    if (issue) begin
      resp_idx  <= rd_idx;
      resp_last <= (issued == CNT_LAST);
    end
    if (finish) begin
      result <= res_next;
    end
  end

  `ASSERT_ALWAYS(a_reset_state, clk, rst |=> (busy && !done), "reset did not idle the outputs")
  `ASSERT_RST(a_done_idle, clk, rst, done |-> !busy, "result strobe while busy")
  `ASSERT_RST(a_accept_busy, clk, rst, (start && !busy) |=> busy, "accepted beat did not raise busy")
  `ASSERT_RST(a_found_key, clk, rst, (done && result.status == ST_FOUND) |-> (result.found_key == item_q.key), "found key differs from request")
  `ASSERT_RST(a_miss_zero, clk, rst, (done && (result.status == ST_FULL || result.status == ST_NOT_FOUND)) |-> (result.slot == '0 && result.found_key == '0 && result.found_data == '0), "miss result not zeroed")

endmodule

@@ tb/tb_linear_probe_hash_table.sv @@
// ---------------------------------------------------------------------------
// tb_linear_probe_hash_table
// Self-checking bench for the linear probing hash table. A queue of insert
// and search beats feeds a falling-edge driver. A rising-edge monitor keeps
// a shadow table that predicts each answer, and checks every done strobe
// against the oldest prediction. A directed sequence covers wrap, collision,
// duplicate keys, the empty-slot stop and the full table. A random sequence
// of mostly searches over the full table follows.
// ---------------------------------------------------------------------------
module tb_linear_probe_hash_table;
  import lph_pkg::*;

  localparam int NUM_SLOTS   = TABLE_SIZE_DEF;
  localparam int RAND_BEATS  = 700;
  localparam int QUIET_TAIL  = 100;   // last beats sent with no idle gaps
  localparam int SETTLE_CYC  = 24;    // covers the longest probe, with margin
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    in_item_t item;
    bit       drain_first;   // hold until every answer is back
  } beat_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  in_item_t  request = '0;
  logic      busy;
  logic      done;
  out_item_t result;

  linear_probe_hash_table DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  // Shadow table
  logic              shadow_valid [NUM_SLOTS];
  logic [KEY_W-1:0]  shadow_key   [NUM_SLOTS];
  logic [DATA_W-1:0] shadow_data  [NUM_SLOTS];

  beat_t       pending_beats[$];
  out_item_t   answers_due[$];
  int          stored_keys[$];
  int          planned_inserts = 0;
  int          beats_planned = 0;
  int          beats_taken = 0;
  int          answers_seen = 0;
  int          status_count [4];
  int          err_count = 0;
  int          idle_left = 0;
  int          cycle_count = 0;
  bit          beat_taken = 1'b0;

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Give up on a hang
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles", cycle_count);
      $display("linear_probe_hash_table test failed");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  // Walk the probe path, update the shadow table and return the answer
  function automatic out_item_t probe_table(input in_item_t req);
    out_item_t ans;
    int        home;
    int        idx;
    ans  = '{status: ST_NOT_FOUND, default: '0};
    home = int'(req.key) % NUM_SLOTS;
    if (req.action == ACT_INSERT) begin
      ans.status = ST_FULL;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        idx = (home + s) % NUM_SLOTS;
        if (!shadow_valid[idx]) begin
          shadow_valid[idx] = 1'b1;
          shadow_key[idx]   = req.key;
          shadow_data[idx]  = req.entry_data;
          ans.status     = ST_INSERTED;
          ans.slot       = idx[SLOT_W-1:0];
          ans.found_key  = req.key;
          ans.found_data = req.entry_data;
          return ans;
        end
      end
      return ans;
    end
    for (int s = 0; s < NUM_SLOTS; s++) begin
      idx = (home + s) % NUM_SLOTS;
      if (!shadow_valid[idx]) return ans;
      if (shadow_key[idx] == req.key) begin
        ans.status     = ST_FOUND;
        ans.slot       = idx[SLOT_W-1:0];
        ans.found_key  = shadow_key[idx];
        ans.found_data = shadow_data[idx];
        return ans;
      end
    end
    return ans;
  endfunction

  // Queue one beat; remember keys that will land in the table
  task automatic add_beat(input action_t act, input int key, input logic [DATA_W-1:0] data,
                          input bit drain_first = 1'b0);
    beat_t b;
    b.item.action     = act;
    b.item.key        = key[KEY_W-1:0];
    b.item.entry_data = data;
    b.drain_first     = drain_first;
    pending_beats.push_back(b);
    beats_planned++;
    if (act == ACT_INSERT && planned_inserts < NUM_SLOTS) begin
      stored_keys.push_back(key);
      planned_inserts++;
    end
  endtask

  // Drive beats at the falling edge
  always @(negedge clk) begin : drive_beats
    logic     nxt_start;
    in_item_t nxt_req;
    bit       may_send;
    nxt_start = start;
    nxt_req   = request;
    if (rst) begin
      nxt_start = 1'b0;
    end else if (!start || beat_taken) begin
      nxt_start = 1'b0;
      // open an idle burst now and then, never near the end
      if (beat_taken && pending_beats.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
        idle_left = $urandom_range(1, 6);
      if (idle_left > 0) begin
        idle_left--;
      end else if (pending_beats.size() > 0) begin
        may_send = !pending_beats[0].drain_first || (answers_due.size() == 0);
        if (may_send) begin
          nxt_req   = pending_beats[0].item;
          nxt_start = 1'b1;
          void'(pending_beats.pop_front());
        end
      end
    end
    start   <= nxt_start;
    request <= nxt_req;
  end

  // Check answers and predict accepted beats at the rising edge
  always @(posedge clk) begin : watch_beats
    out_item_t want;
    if (rst) begin
      beat_taken = 1'b0;
    end else begin
      if (done) begin
        answers_seen++;
        if (answers_due.size() == 0) begin
          report_error($sformatf("answer with none due: status %0d slot %0d",
                                 result.status, result.slot));
        end else begin
          want = answers_due.pop_front();
          if (result.status !== want.status)
            report_error($sformatf("answer %0d status %0d, want %0d",
                                   answers_seen, result.status, want.status));
          if (result.slot !== want.slot)
            report_error($sformatf("answer %0d slot %0d, want %0d",
                                   answers_seen, result.slot, want.slot));
          if (result.found_key !== want.found_key)
            report_error($sformatf("answer %0d key %h, want %h",
                                   answers_seen, result.found_key, want.found_key));
          if (result.found_data !== want.found_data)
            report_error($sformatf("answer %0d data %h, want %h",
                                   answers_seen, result.found_data, want.found_data));
        end
      end
      beat_taken = start && !busy;
      if (beat_taken) begin
        want = probe_table(request);
        status_count[want.status]++;
        answers_due.push_back(want);
        beats_taken++;
      end
    end
  end

  // Stimulus, reset and wrap-up
  initial begin
    int        pick;
    int        key;
    action_t   act;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i]   = '0;
      shadow_data[i]  = '0;
    end
    for (int i = 0; i < 4; i++) status_count[i] = 0;

    // searches on an empty table
    add_beat(ACT_SEARCH, 16'h0000, 32'h0000_0000);
    add_beat(ACT_SEARCH, 16'hFFFF, 32'hFFFF_FFFF);
    // build a cluster at the top slot that wraps to the bottom
    add_beat(ACT_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    add_beat(ACT_INSERT, 16'h0007, 32'h0000_0000);
    add_beat(ACT_INSERT, 16'h0000, 32'hA5A5_5A5A);
    add_beat(ACT_SEARCH, 16'h0007, 32'h0);
    add_beat(ACT_SEARCH, 16'h0000, 32'h0);
    // absent key: stop at the first empty slot after the cluster
    add_beat(ACT_SEARCH, 16'h000F, 32'h0);
    add_beat(ACT_INSERT, 16'h0003, 32'h0000_1234);
    // duplicate key: second copy lands later, search returns the first
    add_beat(ACT_INSERT, 16'h0007, 32'hDEAD_BEEF);
    add_beat(ACT_SEARCH, 16'h0007, 32'h0);
    add_beat(ACT_SEARCH, 16'hFFFF, 32'h5555_AAAA);
    // fill the rest
    add_beat(ACT_INSERT, 16'h8004, 32'h8000_0001);
    add_beat(ACT_INSERT, 16'h0105, 32'h7FFF_FFFE);
    add_beat(ACT_INSERT, 16'h7FFE, 32'h0F0F_F0F0);
    // full table: inserts refused, absent keys swept all the way round
    add_beat(ACT_INSERT, 16'h1234, 32'h1357_9BDF, 1'b1);
    add_beat(ACT_INSERT, 16'h0000, 32'hFFFF_FFFF);
    add_beat(ACT_SEARCH, 16'h0009, 32'h0);
    add_beat(ACT_SEARCH, 16'hFFF7, 32'h0);
    add_beat(ACT_SEARCH, 16'h0003, 32'h0);
    add_beat(ACT_SEARCH, 16'h7FFE, 32'h0);

    // random mix, mostly searches for stored keys
    for (int n = 0; n < RAND_BEATS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        act = ACT_SEARCH;
        key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      end else begin
        act = (pick < 80) ? ACT_SEARCH : ACT_INSERT;
        key = $urandom_range(0, 65535);
      end
      add_beat(act, key, $urandom, ($urandom_range(0, 49) == 0));
    end

    // hold reset, then release at a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // drain every beat and answer, then give late strobes a chance
    while (beats_taken < beats_planned || answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (answers_due.size() != 0)
      report_error($sformatf("%0d answers never arrived", answers_due.size()));

    $display("Covered %0d beats in %0d cycles: %0d inserted, %0d refused full,",
             beats_taken, cycle_count, status_count[ST_INSERTED], status_count[ST_FULL]);
    $display("%0d searches found, %0d not found; %0d errors",
             status_count[ST_FOUND], status_count[ST_NOT_FOUND], err_count);
    if (err_count == 0) begin
      $display("linear_probe_hash_table test passed");
    end else begin
      $display("linear_probe_hash_table test failed");
    end
    $finish;
  end

endmodule
